// ===== sv/biq_pkg.sv =====
// Package: widths, fixed-point constants, types and saturation helpers for the biquad.
package biq_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int COEF_WIDTH   = 32;
   localparam int STATE_WIDTH  = 40;

   localparam int SAMPLE_FRAC = SAMPLE_WIDTH - 1;
   localparam int COEF_FRAC   = COEF_WIDTH - 4;
   localparam int STATE_FRAC  = STATE_WIDTH - 9;

   localparam int NUM_COEF  = 5;
   localparam int CSR_IDX_W = $clog2(NUM_COEF);

   // y is fed to the multiplier in two halves: unsigned low, signed high
   localparam int Y_LO_W = STATE_WIDTH / 2;
   localparam int Y_HI_W = STATE_WIDTH - Y_LO_W;
   localparam int MUL_B_W0 = (SAMPLE_WIDTH > Y_HI_W) ? SAMPLE_WIDTH : Y_HI_W;
   localparam int MUL_B_WIDTH = (MUL_B_W0 > Y_LO_W + 1) ? MUL_B_W0 : Y_LO_W + 1;
   localparam int PROD_W = COEF_WIDTH + MUL_B_WIDTH;

   // accumulator holds a full coefficient times state product plus headroom
   localparam int ACC_W = COEF_WIDTH + STATE_WIDTH + 1;

   localparam int BSH = COEF_FRAC + SAMPLE_FRAC - STATE_FRAC;
   localparam int ASH = COEF_FRAC;
   localparam int OSH = STATE_FRAC - SAMPLE_FRAC;
   localparam int YR_W = STATE_WIDTH + 1 - OSH;

   localparam logic signed [ACC_W-1:0] HALF_B  = ACC_W'(1) << (BSH - 1);
   localparam logic signed [ACC_W-1:0] NEG_RND = (ACC_W'(1) << (ASH - 1)) + ACC_W'(1);
   localparam logic signed [STATE_WIDTH:0] HALF_O = (STATE_WIDTH + 1)'(1) << (OSH - 1);

   localparam logic signed [ACC_W-1:0] STATE_MAX =
      {{(ACC_W - STATE_WIDTH + 1){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] STATE_MIN = ~STATE_MAX;
   localparam logic signed [YR_W-1:0] SAMPLE_MAX =
      {{(YR_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [YR_W-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_B0 = 0,
      REG_B1 = 1,
      REG_B2 = 2,
      REG_A1 = 3,
      REG_A2 = 4
   } biq_reg_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] b0;
      logic signed [COEF_WIDTH-1:0] b1;
      logic signed [COEF_WIDTH-1:0] b2;
      logic signed [COEF_WIDTH-1:0] a1;
      logic signed [COEF_WIDTH-1:0] a2;
   } biq_coef_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MB0,
      ST_RB0,
      ST_Y,
      ST_T1,
      ST_T2,
      ST_A1H,
      ST_A1R,
      ST_D1,
      ST_A2H,
      ST_A2R,
      ST_D2
   } biq_state_type;

   typedef struct packed {
      biq_state_type step;
      logic          load_x;
      logic          clear;
      logic          commit;
   } biq_ctl_type;

   typedef struct packed {
      logic signed [STATE_WIDTH-1:0] value;
      logic                          clip;
   } biq_state_sat_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] value;
      logic                           clip;
   } biq_sample_sat_type;

   function automatic biq_state_sat_type sat_state(input logic signed [ACC_W-1:0] v);
      biq_state_sat_type r;
      if (v > STATE_MAX) begin
         r.value = STATE_MAX[STATE_WIDTH-1:0];
         r.clip  = 1'b1;
      end else if (v < STATE_MIN) begin
         r.value = STATE_MIN[STATE_WIDTH-1:0];
         r.clip  = 1'b1;
      end else begin
         r.value = v[STATE_WIDTH-1:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

   function automatic biq_sample_sat_type sat_sample(input logic signed [YR_W-1:0] v);
      biq_sample_sat_type r;
      if (v > SAMPLE_MAX) begin
         r.value = SAMPLE_MAX[SAMPLE_WIDTH-1:0];
         r.clip  = 1'b1;
      end else if (v < SAMPLE_MIN) begin
         r.value = SAMPLE_MIN[SAMPLE_WIDTH-1:0];
         r.clip  = 1'b1;
      end else begin
         r.value = v[SAMPLE_WIDTH-1:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== sv/biq_if.sv =====
// Interfaces: request and response stream channels of the biquad.
interface biq_req_if import biq_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, command, sample_in, input ready);
   modport sink (input valid, command, sample_in, output ready);
endinterface

interface biq_rsp_if import biq_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           clipped;

   modport source (output valid, sample_out, clipped, input ready);
   modport sink (input valid, sample_out, clipped, output ready);
endinterface

// ===== sv/biq_coef_regs.sv =====
// Coefficient register file written through the CSR port.
module biq_coef_regs import biq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COEF_WIDTH-1:0] csr_data,
   output biq_coef_type          coefs
);

   biq_coef_type coef_ff, coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_B0:  coef_in.b0 = csr_data;
            REG_B1:  coef_in.b1 = csr_data;
            REG_B2:  coef_in.b2 = csr_data;
            REG_A1:  coef_in.a1 = csr_data;
            REG_A2:  coef_in.a2 = csr_data;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= COEF_ONE;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coefs = coef_ff;

endmodule

// ===== sv/biq_ctrl.sv =====
// Sequencer: walks one sample through the shared multiplier and accumulator steps.
module biq_ctrl import biq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_command,
   output logic        req_ready,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output biq_ctl_type ctl
);

   biq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      ctl.step   = state_ff;
      ctl.load_x = 1'b0;
      ctl.clear  = 1'b0;
      ctl.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command) begin
                  ctl.clear = 1'b1;
               end else begin
                  ctl.load_x = 1'b1;
                  state_in   = ST_MB0;
               end
            end
         end
         ST_MB0: state_in = ST_RB0;
         ST_RB0: state_in = ST_Y;
         ST_Y:   state_in = ST_T1;
         ST_T1:  state_in = ST_T2;
         ST_T2:  state_in = ST_A1H;
         ST_A1H: state_in = ST_A1R;
         ST_A1R: state_in = ST_D1;
         ST_D1:  state_in = ST_A2H;
         ST_A2H: state_in = ST_A2R;
         ST_A2R: state_in = ST_D2;
         ST_D2: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/biq_datapath.sv =====
// Datapath: shared multiplier, accumulator, delay state and output register.
module biq_datapath import biq_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  biq_coef_type                   coefs,
   input  biq_ctl_type                    ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [SAMPLE_WIDTH-1:0] sample_out,
   output logic                           clipped
);

   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [ACC_W-1:0]        t1_ff, t1_in;
   logic signed [ACC_W-1:0]        t2_ff, t2_in;
   logic signed [STATE_WIDTH-1:0]  y_ff, y_in;
   logic signed [YR_W-1:0]         yr_ff, yr_in;
   logic signed [STATE_WIDTH-1:0]  d1_ff, d1_in;
   logic signed [STATE_WIDTH-1:0]  d2_ff, d2_in;
   logic                           clip_ff, clip_in;
   logic signed [SAMPLE_WIDTH-1:0] out_sample_ff, out_sample_in;
   logic                           out_clip_ff, out_clip_in;

   logic signed [COEF_WIDTH-1:0]   mul_a;
   logic signed [MUL_B_WIDTH-1:0]  mul_b;
   logic                           mul_en;
   logic signed [MUL_B_WIDTH-1:0]  op_x, op_ylo, op_yhi;
   logic signed [ACC_W-1:0]        prod_ext, b_term, a_term;
   logic signed [STATE_WIDTH:0]    y_sum;
   biq_state_sat_type              sat_s;
   biq_sample_sat_type             sat_o;

   assign op_x     = MUL_B_WIDTH'(x_ff);
   assign op_ylo   = MUL_B_WIDTH'(signed'({1'b0, y_ff[Y_LO_W-1:0]}));
   assign op_yhi   = MUL_B_WIDTH'(signed'(y_ff[STATE_WIDTH-1:Y_LO_W]));
   assign prod_ext = ACC_W'(prod_ff);
   assign b_term   = acc_ff >>> BSH;
   assign a_term   = acc_ff >>> ASH;
   assign y_sum    = (STATE_WIDTH + 1)'(y_ff) + HALF_O;
   assign prod_in  = mul_en ? mul_a * mul_b : prod_ff;

   always_comb begin
      x_in          = x_ff;
      acc_in        = acc_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      y_in          = y_ff;
      yr_in         = yr_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      clip_in       = clip_ff;
      out_sample_in = out_sample_ff;
      out_clip_in   = out_clip_ff;
      mul_en        = 1'b0;
      mul_a         = coefs.b0;
      mul_b         = op_x;
      sat_s         = sat_state(t2_ff + a_term);
      sat_o         = sat_sample(yr_ff);
      unique case (ctl.step)
         ST_IDLE: begin
            if (ctl.load_x) begin
               x_in    = sample_in;
               clip_in = 1'b0;
            end
            if (ctl.clear) begin
               d1_in = '0;
               d2_in = '0;
            end
         end
         ST_MB0: begin
            mul_en = 1'b1;
         end
         ST_RB0: begin
            acc_in = prod_ext + HALF_B;
            mul_en = 1'b1;
            mul_a  = coefs.b1;
         end
         ST_Y: begin
            sat_s   = sat_state(b_term + ACC_W'(d1_ff));
            y_in    = sat_s.value;
            clip_in = clip_ff | sat_s.clip;
            acc_in  = prod_ext + HALF_B;
            mul_en  = 1'b1;
            mul_a   = coefs.b2;
         end
         ST_T1: begin
            t1_in  = b_term + ACC_W'(d2_ff);
            yr_in  = YR_W'(y_sum >>> OSH);
            acc_in = prod_ext + HALF_B;
            mul_en = 1'b1;
            mul_a  = coefs.a1;
            mul_b  = op_ylo;
         end
         ST_T2: begin
            t2_in  = b_term;
            acc_in = prod_ext;
            mul_en = 1'b1;
            mul_a  = coefs.a1;
            mul_b  = op_yhi;
         end
         ST_A1H: begin
            acc_in = acc_ff + (prod_ext <<< Y_LO_W);
            mul_en = 1'b1;
            mul_a  = coefs.a2;
            mul_b  = op_ylo;
         end
         ST_A1R: begin
            // negate and round half up in one pass: ~p + 1 + half
            acc_in = ~acc_ff + NEG_RND;
         end
         ST_D1: begin
            sat_s   = sat_state(t1_ff + a_term);
            d1_in   = sat_s.value;
            clip_in = clip_ff | sat_s.clip;
            acc_in  = prod_ext;
            mul_en  = 1'b1;
            mul_a   = coefs.a2;
            mul_b   = op_yhi;
         end
         ST_A2H: begin
            acc_in = acc_ff + (prod_ext <<< Y_LO_W);
         end
         ST_A2R: begin
            acc_in = ~acc_ff + NEG_RND;
         end
         ST_D2: begin
            if (ctl.commit) begin
               d2_in         = sat_s.value;
               out_sample_in = sat_o.value;
               out_clip_in   = clip_ff | sat_s.clip | sat_o.clip;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      t1_ff         <= t1_in;
      t2_ff         <= t2_in;
      y_ff          <= y_in;
      yr_ff         <= yr_in;
      clip_ff       <= clip_in;
      out_sample_ff <= out_sample_in;
      out_clip_ff   <= out_clip_in;
   end

   assign sample_out = out_sample_ff;
   assign clipped    = out_clip_ff;

endmodule

// ===== sv/biquad_iir_filter.sv =====
// Biquad IIR section, transposed direct form II, 24-bit samples, Q4.28 coefficients,
// 40-bit Q9.31 saturating state. From acceptance to the result register, a filter
// transaction makes seven passes through the single 32x24 multiplier plus the
// accumulator's rounding and saturating sums, one step per cycle unless the last
// step stalls on an untaken response. The block takes one sample at a time; the
// request channel is ready again in the cycle after the result is registered, even
// while it waits. A clear transaction zeroes both delays and returns no response.
module biquad_iir_filter import biq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COEF_WIDTH-1:0] csr_data,
   biq_req_if.sink               req_chan,
   biq_rsp_if.source             rsp_chan
);

   biq_coef_type coefs;
   biq_ctl_type  ctl;

   biq_coef_regs u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coefs     (coefs)
   );

   biq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .ctl         (ctl)
   );

   biq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .coefs      (coefs),
      .ctl        (ctl),
      .sample_in  (req_chan.sample_in),
      .sample_out (rsp_chan.sample_out),
      .clipped    (rsp_chan.clipped)
   );

   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.command && !rsp_chan.valid)
      |=> !rsp_chan.valid)
      else $error("clear transaction produced a response");

   a_rsp_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(ctl.step == ST_D2))
      else $error("response raised outside the final step");

   a_filter_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !req_chan.command) |=> (ctl.step == ST_MB0))
      else $error("filter transaction did not start the sequence");

endmodule
